// ===== rtl/adl_pkg.sv =====
// ----------------------------------------------------------------------------
// adl_pkg
// shared constants, codes, types and the step scale table of the adpcm
// loop decoder
// ----------------------------------------------------------------------------
`default_nettype none

package adl_pkg;

  localparam int unsigned SRC_BYTES = 65536;
  localparam int unsigned SRC_AW    = $clog2(SRC_BYTES);

  localparam logic [17:0] POS_LIMIT = 18'd131072;

  localparam logic [14:0] STEP_MIN  = 15'd127;
  localparam logic [14:0] STEP_MAX  = 15'd24576;

  localparam logic signed [17:0] PRED_MAX = 18'sd32767;
  localparam logic signed [17:0] PRED_MIN = -18'sd32768;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_DECODE  = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_BEGIN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_STOP    = 8'd3;

  typedef struct packed {
    logic signed [15:0] pred;
    logic [14:0]        step;
    logic [17:0]        pos;
    logic               snap_taken;
    logic signed [15:0] snap_pred;
    logic [14:0]        snap_step;
  } dec_state_t;

  typedef struct packed {
    logic [17:0] sample_count;
    logic        loop_en;
    logic [16:0] loop_begin;
    logic [17:0] loop_stop;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               drained;
    logic               wrapped;
  } result_t;

  function automatic logic [9:0] step_scale(input logic [2:0] mag);
    logic [9:0] s;
    case (mag)
      3'd4:    s = 10'h133;
      3'd5:    s = 10'h199;
      3'd6:    s = 10'h200;
      3'd7:    s = 10'h266;
      default: s = 10'h0E6;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/adl_in_if.sv =====
// ----------------------------------------------------------------------------
// adl_in_if
// request channel: load, decode and restart items
// ----------------------------------------------------------------------------
`default_nettype none

interface adl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] load_addr;
  logic [7:0]  load_byte;

  modport source (output valid, output req_type, output load_addr, output load_byte,
                  input ready);
  modport sink   (input valid, input req_type, input load_addr, input load_byte,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/adl_out_if.sv =====
// ----------------------------------------------------------------------------
// adl_out_if
// sample channel: one decoded pcm sample with its flags
// ----------------------------------------------------------------------------
`default_nettype none

interface adl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               drained;
  logic               wrapped;

  modport source (output valid, output sample, output drained, output wrapped,
                  input ready);
  modport sink   (input valid, input sample, input drained, input wrapped,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/adl_cfg_if.sv =====
// ----------------------------------------------------------------------------
// adl_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
`default_nettype none

interface adl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [adl_pkg::CFG_IDX_W-1:0]    addr;
  logic [adl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/adpcm_loop_decoder_core.sv =====
// ----------------------------------------------------------------------------
// adpcm_loop_decoder_core
// looping 4-bit adpcm decoder with a byte store of codes
// ----------------------------------------------------------------------------
// Load and restart items complete when accepted. A decode item has two
// steps: the store read of the code byte, then the predictor, step and
// position update that the next decode reads, held while an untaken sample
// waits in the output register; the next item is taken while it is pending.
// The store needs no clearing after reset; unloaded bytes read as anything.
`default_nettype none

module adpcm_loop_decoder_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  adl_in_if.sink     in_ch,
  adl_out_if.source  out_ch,
  adl_cfg_if.sink    cfg_ch
);

  adl_pkg::dec_state_t state_r;
  adl_pkg::dec_state_t state_nxt;
  adl_pkg::dec_state_t state_rst;
  adl_pkg::cfg_regs_t  cfg_r;
  adl_pkg::result_t    res;
  adl_pkg::result_t    out_r;

  logic                            busy_r;
  logic                            out_valid_r;
  logic                            in_xfer;
  logic                            fire;
  logic                            load_in_range;
  logic [adl_pkg::SRC_AW+15:0]     load_addr_w;
  logic [adl_pkg::SRC_AW+16:0]     rd_addr_w;
  logic [7:0]                      src_byte;

  assign state_rst = '{pred: '0, step: adl_pkg::STEP_MIN, pos: '0, snap_taken: 1'b0,
                       snap_pred: '0, snap_step: adl_pkg::STEP_MIN};

  assign in_ch.ready = !busy_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign fire        = busy_r && (!out_valid_r || out_ch.ready);

  assign load_addr_w   = {{adl_pkg::SRC_AW{1'b0}}, in_ch.load_addr};
  assign load_in_range = load_addr_w < (adl_pkg::SRC_AW + 16)'(adl_pkg::SRC_BYTES);
  assign rd_addr_w     = {{adl_pkg::SRC_AW{1'b0}}, state_r.pos[17:1]};

  adl_store u_store (
    .clk     (clk),
    .wr_en   (in_xfer && (in_ch.req_type == adl_pkg::REQ_LOAD) && load_in_range),
    .wr_addr (load_addr_w[adl_pkg::SRC_AW-1:0]),
    .wr_data (in_ch.load_byte),
    .rd_en   (in_xfer && (in_ch.req_type == adl_pkg::REQ_DECODE)),
    .rd_addr (rd_addr_w[adl_pkg::SRC_AW-1:0]),
    .rd_data (src_byte)
  );

  adl_step u_step (
    .st       (state_r),
    .cfg      (cfg_r),
    .src_byte (src_byte),
    .st_nxt   (state_nxt),
    .res      (res)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= state_rst;
    end else if (in_xfer && (in_ch.req_type == adl_pkg::REQ_RESTART)) begin
      state_r <= state_rst;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_xfer && (in_ch.req_type == adl_pkg::REQ_DECODE)) begin
      busy_r <= 1'b1;
    end else if (fire) begin
      busy_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.sample  = out_r.sample;
  assign out_ch.drained = out_r.drained;
  assign out_ch.wrapped = out_r.wrapped;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        adl_pkg::CFG_SAMPLE_COUNT: cfg_r.sample_count <= cfg_ch.data[17:0];
        adl_pkg::CFG_LOOP_ENABLE:  cfg_r.loop_en      <= cfg_ch.data[0];
        adl_pkg::CFG_LOOP_BEGIN:   cfg_r.loop_begin   <= cfg_ch.data[16:0];
        adl_pkg::CFG_LOOP_STOP:    cfg_r.loop_stop    <= cfg_ch.data[17:0];
        default: ;
      endcase
    end
  end

  a_decode_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_ch.req_type == adl_pkg::REQ_DECODE) |=> busy_r)
    else $error("decode transfer did not start the update cycle");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.step >= adl_pkg::STEP_MIN) && (state_r.step <= adl_pkg::STEP_MAX))
    else $error("step size out of range");

  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pos <= adl_pkg::POS_LIMIT)
    else $error("read position beyond limit");

  a_drained_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.drained |-> (out_r.sample == 16'sd0) && !out_r.wrapped)
    else $error("drained sample carries data");

  a_wrap_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.wrapped |=> state_r.pos == {1'b0, $past(cfg_r.loop_begin)})
    else $error("wrap did not return to loop start");

endmodule

`default_nettype wire

// ===== rtl/adl_store.sv =====
// ----------------------------------------------------------------------------
// adl_store
// source code byte store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module adl_store (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [adl_pkg::SRC_AW-1:0] wr_addr,
  input  wire logic [7:0]                 wr_data,
  input  wire logic                       rd_en,
  input  wire logic [adl_pkg::SRC_AW-1:0] rd_addr,
  output logic      [7:0]                 rd_data
);

  logic [7:0] mem [adl_pkg::SRC_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adl_step.sv =====
// ----------------------------------------------------------------------------
// adl_step
// one decode step: nibble select, predictor and step update, loop capture
// and wrap, drained one-shot
// ----------------------------------------------------------------------------
`default_nettype none

module adl_step (
  input  wire adl_pkg::dec_state_t st,
  input  wire adl_pkg::cfg_regs_t  cfg,
  input  wire logic [7:0]          src_byte,
  output adl_pkg::dec_state_t      st_nxt,
  output adl_pkg::result_t         res
);

  logic               drained;
  logic               capture;
  logic               wrap;
  logic [3:0]         code;
  logic [2:0]         mag;
  logic [18:0]        prod_d;
  logic [15:0]        delta;
  logic signed [17:0] delta_s;
  logic signed [17:0] sum;
  logic signed [15:0] pred_new;
  logic [24:0]        prod_s;
  logic [16:0]        step_sc;
  logic [14:0]        step_new;
  logic [17:0]        pos_inc;
  logic signed [15:0] snap_pred_eff;
  logic [14:0]        snap_step_eff;

  assign drained = !cfg.loop_en && (st.pos >= cfg.sample_count);
  assign capture = cfg.loop_en && !st.snap_taken && (st.pos == {1'b0, cfg.loop_begin});

  assign code = st.pos[0] ? src_byte[7:4] : src_byte[3:0];
  assign mag  = code[2:0];

  // step * (2m+1) / 8, step is positive so a shift truncates toward zero
  assign prod_d  = 19'(st.step) * 19'({mag, 1'b1});
  assign delta   = prod_d[18:3];
  assign delta_s = $signed({2'b00, delta});
  assign sum     = $signed({{2{st.pred[15]}}, st.pred}) + (code[3] ? -delta_s : delta_s);

  always_comb begin
    if (sum > adl_pkg::PRED_MAX) begin
      pred_new = adl_pkg::PRED_MAX[15:0];
    end else if (sum < adl_pkg::PRED_MIN) begin
      pred_new = adl_pkg::PRED_MIN[15:0];
    end else begin
      pred_new = sum[15:0];
    end
  end

  assign prod_s  = 25'(st.step) * 25'(adl_pkg::step_scale(mag));
  assign step_sc = prod_s[24:8];

  always_comb begin
    if (step_sc < 17'(adl_pkg::STEP_MIN)) begin
      step_new = adl_pkg::STEP_MIN;
    end else if (step_sc > 17'(adl_pkg::STEP_MAX)) begin
      step_new = adl_pkg::STEP_MAX;
    end else begin
      step_new = step_sc[14:0];
    end
  end

  assign pos_inc = (st.pos < adl_pkg::POS_LIMIT) ? st.pos + 18'd1 : st.pos;
  assign wrap    = cfg.loop_en && (pos_inc >= cfg.loop_stop);

  // a capture in this step is what the wrap restores
  assign snap_pred_eff = capture ? st.pred : st.snap_pred;
  assign snap_step_eff = capture ? st.step : st.snap_step;

  always_comb begin
    if (drained) begin
      st_nxt      = st;
      res.sample  = '0;
      res.drained = 1'b1;
      res.wrapped = 1'b0;
    end else begin
      st_nxt.pred       = wrap ? snap_pred_eff : pred_new;
      st_nxt.step       = wrap ? snap_step_eff : step_new;
      st_nxt.pos        = wrap ? {1'b0, cfg.loop_begin} : pos_inc;
      st_nxt.snap_taken = st.snap_taken | capture;
      st_nxt.snap_pred  = snap_pred_eff;
      st_nxt.snap_step  = snap_step_eff;
      res.sample        = pred_new;
      res.drained       = 1'b0;
      res.wrapped       = wrap;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for adpcm_loop_decoder_core. A driver pops load,
// decode, restart and unused requests from a backlog and runs each accepted
// transfer through a bit-accurate model of the decoder. The model covers the
// code store, the predictor and step clamps, the loop snapshot and wrap, and
// one-shot drain. A monitor checks every sample transfer against the oldest
// expected sample. Directed cases come first. Random phases with fresh
// register settings and different idle and stall rates follow.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int NUM_PHASES   = 8;
  localparam int POS_CAP      = 131072;
  localparam int PCM_HI       = 32767;
  localparam int PCM_LO       = -32768;
  localparam int STEP_LO      = 127;
  localparam int STEP_HI      = 24576;
  localparam int STEP_GROWTH [8] = '{'h0E6, 'h0E6, 'h0E6, 'h0E6, 'h133, 'h199, 'h200, 'h266};

  localparam logic [1:0]                    REQ_UNUSED = 2'd3;
  localparam logic [adl_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 8'd255;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] addr;
    logic [7:0]  data;
  } pcm_req_t;

  logic clk = 1'b0;
  logic rst_n;
  logic hold_trig;

  adl_in_if  in_ch();
  adl_out_if out_ch();
  adl_cfg_if cfg_ch();

  adpcm_loop_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // decoder model state
  logic [7:0]         code_mem [65536];
  logic signed [15:0] pcm_pred;
  logic [14:0]        pcm_step;
  logic [17:0]        rd_pos;
  bit                 snap_valid;
  logic signed [15:0] snap_pred;
  logic [14:0]        snap_step;

  // register copies
  logic [17:0] cfg_count;
  bit          cfg_loop;
  logic [16:0] cfg_lstart;
  logic [17:0] cfg_lend;

  // stimulus planning
  bit          byte_loaded [65536];
  logic [17:0] plan_pos;

  pcm_req_t          req_backlog [$];
  adl_pkg::result_t  expected_pcm [$];
  pcm_req_t          cur_req;
  adl_pkg::result_t  pcm_head;

  int pushed_cnt   = 0;
  int accepted_cnt = 0;
  int errs         = 0;
  int cycle_cnt    = 0;
  int send_idle    = 0;
  int recv_stall   = 0;
  int hold_left    = 0;

  task automatic clear_decoder();
    pcm_pred   = '0;
    pcm_step   = 15'(STEP_LO);
    rd_pos     = '0;
    snap_valid = 1'b0;
    snap_pred  = '0;
    snap_step  = 15'(STEP_LO);
  endtask

  task automatic apply_request(input pcm_req_t rq);
    logic [7:0]       cbyte;
    logic [3:0]       code;
    int               mag;
    int               stp;
    int               delta;
    int               acc;
    adl_pkg::result_t want;
    if (rq.req == adl_pkg::REQ_LOAD) begin
      code_mem[rq.addr] = rq.data;
    end else if (rq.req == adl_pkg::REQ_RESTART) begin
      clear_decoder();
    end else if (rq.req == adl_pkg::REQ_DECODE) begin
      want = '0;
      if (!cfg_loop && rd_pos >= cfg_count) begin
        want.drained = 1'b1;
      end else begin
        if (cfg_loop && !snap_valid && rd_pos == {1'b0, cfg_lstart}) begin
          snap_pred  = pcm_pred;
          snap_step  = pcm_step;
          snap_valid = 1'b1;
        end
        cbyte = code_mem[rd_pos[16:1]];
        code  = rd_pos[0] ? cbyte[7:4] : cbyte[3:0];
        mag   = code[2:0];
        stp   = pcm_step;
        delta = stp * (2 * mag + 1) / 8;
        if (code[3]) delta = -delta;
        acc = pcm_pred + delta;
        if (acc > PCM_HI) acc = PCM_HI;
        else if (acc < PCM_LO) acc = PCM_LO;
        pcm_pred    = acc[15:0];
        want.sample = acc[15:0];
        stp = (stp * STEP_GROWTH[mag]) >> 8;
        if (stp < STEP_LO) stp = STEP_LO;
        else if (stp > STEP_HI) stp = STEP_HI;
        pcm_step = stp[14:0];
        if (rd_pos < POS_CAP) rd_pos = rd_pos + 1'b1;
        if (cfg_loop && rd_pos >= cfg_lend) begin
          pcm_pred     = snap_pred;
          pcm_step     = snap_step;
          rd_pos       = {1'b0, cfg_lstart};
          want.wrapped = 1'b1;
        end
      end
      expected_pcm.push_back(want);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.req_type  <= adl_pkg::REQ_LOAD;
      in_ch.load_addr <= '0;
      in_ch.load_byte <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(cur_req);
        accepted_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_req = req_backlog.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.req_type  <= cur_req.req;
          in_ch.load_addr <= cur_req.addr;
          in_ch.load_byte <= cur_req.data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_trig) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // sample monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pcm.size() == 0) begin
          errs++;
          if (errs <= 40)
            $display("%0t: unexpected sample %0d drained %0b wrapped %0b", $time,
                     out_ch.sample, out_ch.drained, out_ch.wrapped);
        end else begin
          pcm_head = expected_pcm.pop_front();
          if (out_ch.sample !== pcm_head.sample || out_ch.drained !== pcm_head.drained ||
              out_ch.wrapped !== pcm_head.wrapped) begin
            errs++;
            if (errs <= 40)
              $display("%0t: sample mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                       $time, pcm_head.sample, pcm_head.drained, pcm_head.wrapped,
                       out_ch.sample, out_ch.drained, out_ch.wrapped);
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic put_item(input logic [1:0] req, input logic [15:0] addr,
                          input logic [7:0] data);
    pcm_req_t rq;
    rq.req  = req;
    rq.addr = addr;
    rq.data = data;
    req_backlog.push_back(rq);
    pushed_cnt++;
  endtask

  task automatic put_load(input logic [15:0] addr, input logic [7:0] data);
    put_item(adl_pkg::REQ_LOAD, addr, data);
    byte_loaded[addr] = 1'b1;
  endtask

  // a decode that reads the store is preceded by a load of its byte if needed
  task automatic put_decode();
    if (cfg_loop || plan_pos < cfg_count) begin
      if (!byte_loaded[plan_pos[16:1]]) put_load(plan_pos[16:1], 8'($urandom_range(255)));
      if (plan_pos < POS_CAP) plan_pos = plan_pos + 1'b1;
      if (cfg_loop && plan_pos >= cfg_lend) plan_pos = {1'b0, cfg_lstart};
    end
    put_item(adl_pkg::REQ_DECODE, 16'($urandom_range(65535)), 8'($urandom_range(255)));
  endtask

  task automatic put_restart();
    put_item(adl_pkg::REQ_RESTART, 16'($urandom_range(65535)), 8'($urandom_range(255)));
    plan_pos = '0;
  endtask

  task automatic put_noise();
    put_item(REQ_UNUSED, 16'($urandom_range(65535)), 8'($urandom_range(255)));
  endtask

  task automatic cfg_write(input logic [adl_pkg::CFG_IDX_W-1:0] idx, input logic [17:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      adl_pkg::CFG_SAMPLE_COUNT: cfg_count  = val;
      adl_pkg::CFG_LOOP_ENABLE:  cfg_loop   = val[0];
      adl_pkg::CFG_LOOP_BEGIN:   cfg_lstart = val[16:0];
      adl_pkg::CFG_LOOP_STOP:    cfg_lend   = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (accepted_cnt != pushed_cnt || expected_pcm.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one decode with loop end at zero wraps straight to the new loop start
  task automatic seek(input logic [16:0] target);
    cfg_write(adl_pkg::CFG_LOOP_ENABLE, 18'd1);
    cfg_write(adl_pkg::CFG_LOOP_BEGIN, {1'b0, target});
    cfg_write(adl_pkg::CFG_LOOP_STOP, 18'd0);
    put_decode();
    settle();
  endtask

  initial begin
    int          ph;
    int          n;
    int          sel;
    int          hs;
    logic [17:0] cnt;
    rst_n           = 1'b0;
    hold_trig       = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.addr     = '0;
    cfg_ch.data     = '0;
    cfg_count       = '0;
    cfg_loop        = 1'b0;
    cfg_lstart      = '0;
    cfg_lend        = '0;
    plan_pos        = '0;
    clear_decoder();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-length one-shot drains at once
    put_decode();
    put_noise();
    settle();
    cfg_write(adl_pkg::CFG_SAMPLE_COUNT, 18'd131072);
    cfg_write(CFG_NO_REG, '1);
    // step floor, then climb into the positive clamp, then the negative clamp
    put_load(16'd0, 8'h00);
    for (n = 1; n < 5; n++) put_load(16'(n), 8'h77);
    put_load(16'd5, 8'hFF);
    put_load(16'hFFFF, 8'hA5);
    repeat (12) put_decode();
    put_restart();
    settle();
    // wrap with no snapshot taken, then wrap at the last position
    seek(17'd131071);
    cfg_write(adl_pkg::CFG_LOOP_STOP, 18'd131072);
    put_decode();
    settle();
    cfg_write(adl_pkg::CFG_LOOP_ENABLE, 18'd0);
    repeat (2) put_decode();
    put_restart();
    settle();
    // snapshot at loop start, restore at loop end, no second capture
    cfg_write(adl_pkg::CFG_LOOP_ENABLE, 18'd1);
    cfg_write(adl_pkg::CFG_LOOP_BEGIN, 18'd2);
    cfg_write(adl_pkg::CFG_LOOP_STOP, 18'd5);
    repeat (6) put_decode();
    settle();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle  = 0;
      recv_stall = 0;
      case (ph % 4)
        1: send_idle = 49;
        2: recv_stall = 49;
        3: begin
          send_idle  = 9;
          recv_stall = 9;
        end
        default: ;
      endcase
      case ($urandom_range(3))
        0: begin
          case ($urandom_range(3))
            0: cnt = '0;
            1: cnt = 18'($urandom_range(64, 1));
            2: cnt = 18'($urandom_range(400, 64));
            default: cnt = 18'(POS_CAP);
          endcase
          cfg_write(adl_pkg::CFG_SAMPLE_COUNT, cnt);
          cfg_write(adl_pkg::CFG_LOOP_ENABLE, 18'd0);
          cfg_write(adl_pkg::CFG_LOOP_BEGIN, 18'($urandom_range(131071)));
          cfg_write(adl_pkg::CFG_LOOP_STOP, 18'($urandom_range(POS_CAP)));
        end
        1: begin
          cfg_write(adl_pkg::CFG_SAMPLE_COUNT, 18'($urandom_range(POS_CAP)));
          cfg_write(adl_pkg::CFG_LOOP_ENABLE, 18'd1);
          cfg_write(adl_pkg::CFG_LOOP_BEGIN, 18'($urandom_range(40)));
          cfg_write(adl_pkg::CFG_LOOP_STOP, 18'($urandom_range(80)));
        end
        2: begin
          hs = $urandom_range(131071, 130900);
          cfg_write(adl_pkg::CFG_SAMPLE_COUNT, 18'($urandom_range(POS_CAP)));
          seek(17'(hs));
          cfg_write(adl_pkg::CFG_LOOP_STOP, 18'($urandom_range(POS_CAP, hs + 1)));
        end
        default: begin
          cfg_write(adl_pkg::CFG_SAMPLE_COUNT, 18'($urandom_range(POS_CAP)));
          cfg_write(adl_pkg::CFG_LOOP_ENABLE, 18'd1);
          cfg_write(adl_pkg::CFG_LOOP_BEGIN, 18'($urandom_range(20)));
          cfg_write(adl_pkg::CFG_LOOP_STOP, 18'($urandom_range(1)));
        end
      endcase
      if ($urandom_range(1)) put_restart();
      if (ph == 0) begin
        @(posedge clk);
        hold_trig <= 1'b1;
        @(posedge clk);
        hold_trig <= 1'b0;
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        sel = $urandom_range(99);
        if (sel < 62) begin
          put_decode();
          n++;
        end else if (sel < 80) begin
          put_load(16'($urandom_range(65535)), 8'($urandom_range(255)));
          n++;
        end else if (sel < 92) begin
          put_load(plan_pos[16:1] + 16'($urandom_range(7)), 8'($urandom_range(255)));
          n++;
        end else if (sel < 96) begin
          put_restart();
          n++;
        end else begin
          put_noise();
        end
      end
      settle();
    end

    if (errs == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/adl_pkg.sv
rtl/adl_in_if.sv
rtl/adl_out_if.sv
rtl/adl_cfg_if.sv
rtl/adl_store.sv
rtl/adl_step.sv
rtl/adpcm_loop_decoder_core.sv
tb/tb.sv
